### rtl/outline_segment_bbox_accumulator_macros.svh
// Assertion helpers for the outline bbox accumulator
`ifndef OUTLINE_SEGMENT_BBOX_ACCUMULATOR_MACROS_SVH
`define OUTLINE_SEGMENT_BBOX_ACCUMULATOR_MACROS_SVH
`ifndef ASSERT_OFF
`define OSBA_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("implication check failed");
`define OSBA_ASSERT_NEVER(lbl, clk, rstn, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
		else $error("forbidden condition seen");
`else
`define OSBA_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define OSBA_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

### rtl/osba_pkg.sv
package osba_pkg;

	typedef enum logic [1:0] {
		CMD_MOVETO    = 2'd0,
		CMD_LINETO    = 2'd1,
		CMD_CURVETO   = 2'd2,
		CMD_CLOSEPATH = 2'd3
	} cmd_e;

	localparam logic        REG_FLAT_EPSILON = 1'b0;
	localparam logic [15:0] EPS_RESET        = 16'd131;
	localparam logic [7:0]  COUNT_MAX        = 8'd255;

	typedef logic signed [31:0] coord_t;

	typedef struct packed {
		cmd_e   cmd;
		logic   close_line;
		coord_t px0;
		coord_t py0;
		coord_t px1;
		coord_t py1;
		coord_t px2;
		coord_t py2;
		coord_t px3;
		coord_t py3;
	} in_item_t;

	typedef struct packed {
		logic   accepted;
		coord_t seg_low_x;
		coord_t seg_low_y;
		coord_t seg_high_x;
		coord_t seg_high_y;
		coord_t path_low_x;
		coord_t path_low_y;
		coord_t path_high_x;
		coord_t path_high_y;
	} out_item_t;

	// segment box ahead of the path update
	typedef struct packed {
		cmd_e   cmd;
		logic   close_line;
		coord_t low_x;
		coord_t low_y;
		coord_t high_x;
		coord_t high_y;
	} seg_item_t;

	function automatic coord_t favg(input coord_t a, input coord_t b);
		logic signed [32:0] s;
		s = {a[31], a} + {b[31], b};
		return s[32:1];
	endfunction

	function automatic coord_t smin(input coord_t a, input coord_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic coord_t smax(input coord_t a, input coord_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic logic [32:0] absdiff(input coord_t a, input coord_t b);
		logic [32:0] d;
		d = {a[31], a} - {b[31], b};
		return d[32] ? (33'd0 - d) : d;
	endfunction

endpackage

### rtl/osba_axis_box.sv
module osba_axis_box (
	input  osba_pkg::coord_t p0,
	input  osba_pkg::coord_t p1,
	input  osba_pkg::coord_t p2,
	input  osba_pkg::coord_t p3,
	input  logic             flat,
	output osba_pkg::coord_t lo,
	output osba_pkg::coord_t hi
);
	import osba_pkg::*;

	coord_t l1, mm, r2, l2, r1, md;
	coord_t lo_end, hi_end;
	coord_t lo_crv, hi_crv;

	always_comb begin
		l1 = favg(p0, p1);
		mm = favg(p1, p2);
		r2 = favg(p2, p3);
		l2 = favg(l1, mm);
		r1 = favg(mm, r2);
		md = favg(l2, r1);
		lo_end = smin(p0, p3);
		hi_end = smax(p0, p3);
		lo_crv = smin(smin(smin(l1, l2), smin(md, r1)), r2);
		hi_crv = smax(smax(smax(l1, l2), smax(md, r1)), r2);
		if (flat) begin
			lo = smin(lo_end, mm);
			hi = smax(hi_end, mm);
		end else begin
			lo = smin(lo_end, lo_crv);
			hi = smax(hi_end, hi_crv);
		end
	end

endmodule

### rtl/osba_seg_box.sv
module osba_seg_box (
	input  osba_pkg::in_item_t  item,
	input  logic [15:0]         eps,
	output osba_pkg::seg_item_t seg
);
	import osba_pkg::*;

	logic [32:0] eps_w;
	logic        flat;
	coord_t      cx_lo, cx_hi, cy_lo, cy_hi;

	assign eps_w = {17'd0, eps};
	assign flat  = (absdiff(item.px0, item.px1) < eps_w) &&
	               (absdiff(item.py0, item.py1) < eps_w) &&
	               (absdiff(item.px2, item.px3) < eps_w) &&
	               (absdiff(item.py2, item.py3) < eps_w);

	osba_axis_box u_axis_x (
		.p0(item.px0), .p1(item.px1), .p2(item.px2), .p3(item.px3),
		.flat(flat), .lo(cx_lo), .hi(cx_hi)
	);

	osba_axis_box u_axis_y (
		.p0(item.py0), .p1(item.py1), .p2(item.py2), .p3(item.py3),
		.flat(flat), .lo(cy_lo), .hi(cy_hi)
	);

	always_comb begin
		seg.cmd        = item.cmd;
		seg.close_line = item.close_line;
		case (item.cmd)
			CMD_MOVETO: begin
				seg.low_x  = item.px0;
				seg.high_x = item.px0;
				seg.low_y  = item.py0;
				seg.high_y = item.py0;
			end
			CMD_LINETO: begin
				seg.low_x  = smin(item.px0, item.px3);
				seg.high_x = smax(item.px0, item.px3);
				seg.low_y  = smin(item.py0, item.py3);
				seg.high_y = smax(item.py0, item.py3);
			end
			CMD_CURVETO: begin
				seg.low_x  = cx_lo;
				seg.high_x = cx_hi;
				seg.low_y  = cy_lo;
				seg.high_y = cy_hi;
			end
			default: begin
				seg.low_x  = '0;
				seg.high_x = '0;
				seg.low_y  = '0;
				seg.high_y = '0;
			end
		endcase
	end

endmodule

### rtl/osba_path_acc.sv
module osba_path_acc (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                commit,
	input  osba_pkg::seg_item_t seg,
	output osba_pkg::out_item_t res
);
	import osba_pkg::*;

	coord_t     box_low_x_q, box_low_y_q, box_high_x_q, box_high_y_q;
	logic [7:0] count_q;
	logic       open_q;

	logic       ok;
	coord_t     nlx, nly, nhx, nhy;
	logic [7:0] count_d;
	logic       open_d;

	always_comb begin
		ok      = 1'b0;
		nlx     = box_low_x_q;
		nly     = box_low_y_q;
		nhx     = box_high_x_q;
		nhy     = box_high_y_q;
		count_d = count_q;
		open_d  = open_q;
		case (seg.cmd)
			CMD_MOVETO: begin
				ok  = 1'b1;
				nlx = seg.low_x;
				nly = seg.low_y;
				nhx = seg.high_x;
				nhy = seg.high_y;
			end
			CMD_LINETO, CMD_CURVETO: begin
				ok = open_q && !(seg.cmd == CMD_LINETO && seg.close_line && count_q < 8'd2);
				if (ok) begin
					nlx = smin(box_low_x_q, seg.low_x);
					nly = smin(box_low_y_q, seg.low_y);
					nhx = smax(box_high_x_q, seg.high_x);
					nhy = smax(box_high_y_q, seg.high_y);
				end
			end
			default: begin
				ok = open_q && count_q >= 8'd3;
			end
		endcase
		if (seg.cmd == CMD_MOVETO) begin
			count_d = 8'd1;
			open_d  = 1'b1;
		end else if (ok) begin
			if (count_q != COUNT_MAX)
				count_d = count_q + 8'd1;
			if (seg.cmd == CMD_CLOSEPATH)
				open_d = 1'b0;
		end

		res.accepted    = ok;
		res.seg_low_x   = ok ? seg.low_x  : '0;
		res.seg_low_y   = ok ? seg.low_y  : '0;
		res.seg_high_x  = ok ? seg.high_x : '0;
		res.seg_high_y  = ok ? seg.high_y : '0;
		res.path_low_x  = nlx;
		res.path_low_y  = nly;
		res.path_high_x = nhx;
		res.path_high_y = nhy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_low_x_q  <= '0;
			box_low_y_q  <= '0;
			box_high_x_q <= '0;
			box_high_y_q <= '0;
			count_q      <= '0;
			open_q       <= 1'b0;
		end else if (commit) begin
			box_low_x_q  <= nlx;
			box_low_y_q  <= nly;
			box_high_x_q <= nhx;
			box_high_y_q <= nhy;
			count_q      <= count_d;
			open_q       <= open_d;
		end
	end

endmodule

### rtl/outline_segment_bbox_accumulator.sv
// An accepted item passes through the input, segment and result registers to res_valid.
// Throughput: one item per cycle while res_stall is low; the path box update closes in the result stage.
// Reset (arst_n low, asynchronous): pipeline empty, path box zero, element count zero,
// no path open, flat_epsilon 131.
`include "outline_segment_bbox_accumulator_macros.svh"
module outline_segment_bbox_accumulator (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  osba_pkg::in_item_t  cmd_item,
	output logic                res_valid,
	input  logic                res_stall,
	output osba_pkg::out_item_t res_item,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import osba_pkg::*;

	logic [15:0] eps_q;
	logic        valid_s1, valid_s2, res_valid_q;
	in_item_t    item_s1;
	seg_item_t   seg_d, seg_s2;
	out_item_t   res_d, res_item_q;
	logic        res_load, s2_free, s1_move, s1_free;
	logic        path_ordered, seg_ordered, seg_zero;

	// configuration
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FLAT_EPSILON) ? {16'd0, eps_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			eps_q <= EPS_RESET;
		else if (psel && penable && pwrite && paddr[2] == REG_FLAT_EPSILON)
			eps_q <= pwdata[15:0];
	end

	// flow control
	assign res_load  = valid_s2 && (!res_valid_q || !res_stall);
	assign s2_free   = !valid_s2 || res_load;
	assign s1_move   = valid_s1 && s2_free;
	assign s1_free   = !valid_s1 || s1_move;
	assign cmd_stall = !s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (s1_free)
				valid_s1 <= cmd_valid;
			if (s2_free)
				valid_s2 <= valid_s1;
			if (res_load)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && cmd_valid)
			item_s1 <= cmd_item;
		if (s1_move)
			seg_s2 <= seg_d;
		if (res_load)
			res_item_q <= res_d;
	end

	osba_seg_box u_seg_box (
		.item (item_s1),
		.eps  (eps_q),
		.seg  (seg_d)
	);

	osba_path_acc u_path_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (res_load),
		.seg    (seg_s2),
		.res    (res_d)
	);

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	assign path_ordered = (res_item_q.path_low_x <= res_item_q.path_high_x) &&
	                      (res_item_q.path_low_y <= res_item_q.path_high_y);
	assign seg_ordered  = (res_item_q.seg_low_x <= res_item_q.seg_high_x) &&
	                      (res_item_q.seg_low_y <= res_item_q.seg_high_y);
	assign seg_zero     = (res_item_q.seg_low_x == '0) && (res_item_q.seg_high_x == '0) &&
	                      (res_item_q.seg_low_y == '0) && (res_item_q.seg_high_y == '0);

	`OSBA_ASSERT_NEVER(a_stall_when_empty, clk, arst_n, !valid_s1 && cmd_stall)
	`OSBA_ASSERT_IMPLY(a_path_box_order, clk, arst_n, res_valid_q, path_ordered)
	`OSBA_ASSERT_IMPLY(a_seg_box_order, clk, arst_n, res_valid_q && res_item_q.accepted, seg_ordered)
	`OSBA_ASSERT_IMPLY(a_reject_zero, clk, arst_n, res_valid_q && !res_item_q.accepted, seg_zero)

endmodule
